// File: rtl/core/servo_write_packet_builder_core_assert.svh
// Assertion macros shared by the checker
`ifndef SERVO_WRITE_PACKET_BUILDER_CORE_ASSERT_SVH
`define SERVO_WRITE_PACKET_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SWPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swpb assertion failed");

// Next-cycle implication, disabled while reset is held
`define SWPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swpb assertion failed");

`endif

// File: rtl/core/swpb_pkg.sv
`timescale 1ns / 1ps

package swpb_pkg;

    localparam int unsigned PKT_MAX_BYTES = 11;

    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] OPCODE_WRITE = 8'h03;

    localparam logic [3:0] KIND_MOVE         = 4'd0;
    localparam logic [3:0] KIND_MOVE_TO      = 4'd1;
    localparam logic [3:0] KIND_SPEED        = 4'd2;
    localparam logic [3:0] KIND_CW_LIMIT     = 4'd3;
    localparam logic [3:0] KIND_CCW_LIMIT    = 4'd4;
    localparam logic [3:0] KIND_TORQUE_LIMIT = 4'd5;
    localparam logic [3:0] KIND_MAX_TORQUE   = 4'd6;
    localparam logic [3:0] KIND_LED          = 4'd7;
    localparam logic [3:0] KIND_BAUD         = 4'd8;

    typedef logic [7:0] t_byte;
    typedef t_byte t_pkt [PKT_MAX_BYTES];
    typedef logic [3:0] t_pkt_idx;

    function automatic t_byte kind_addr(input logic [3:0] kind);
        t_byte addr;
        case (kind)
            KIND_MOVE:         addr = 8'h1E;
            KIND_MOVE_TO:      addr = 8'h1E;
            KIND_SPEED:        addr = 8'h20;
            KIND_CW_LIMIT:     addr = 8'h06;
            KIND_CCW_LIMIT:    addr = 8'h08;
            KIND_TORQUE_LIMIT: addr = 8'h22;
            KIND_MAX_TORQUE:   addr = 8'h0E;
            KIND_LED:          addr = 8'h19;
            KIND_BAUD:         addr = 8'h04;
            default:           addr = 8'h00;
        endcase
        return addr;
    endfunction

endpackage

// File: rtl/core/servo_write_packet_builder_core.sv
`timescale 1ns / 1ps
// Servo write-packet builder.
// Input channel: i_in_valid / o_in_stall carry one command item (kind, servo id,
// position, speed, setting word). Output channel: o_out_valid / i_out_stall carry
// one packet byte per item, with o_last_byte high on the closing checksum byte.
// An accepted command is assembled into a packet register, from which its bytes
// move one at a time into the output register. The byte serializer sends one
// byte per cycle while the output is not stalled: a packet has 11 bytes for
// goal position with speed, 9 for the other word commands and 8 for LED and
// baud. The next command is taken in the cycle the checksum byte moves into
// the output register, so packets stream back to back with no gap.
// Commands with an undefined kind are accepted, produce no bytes and leave
// o_in_stall low. While o_out_valid and i_out_stall are high the output byte
// holds and the serializer pauses; o_in_stall stays high until the checksum
// byte has moved into the output register. Synchronous active-low reset marks
// the packet register and output stage empty; nothing is in flight afterwards.
module servo_write_packet_builder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_kind,
    input  logic [7:0] i_servo_id,
    input  logic [15:0] i_goal_position,
    input  logic [15:0] i_moving_speed,
    input  logic [15:0] i_setting_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_packet_byte,
    output logic       o_last_byte
);

    swpb_pkg::t_pkt     r_pkt;
    swpb_pkg::t_pkt     n_pkt;
    swpb_pkg::t_pkt_idx r_last_idx;
    swpb_pkg::t_pkt_idx n_last_idx;
    swpb_pkg::t_pkt_idx r_idx;
    logic               r_busy;
    logic               n_kind_ok;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic out_load;
    logic pkt_done;
    logic in_acc;

    assign out_load   = r_busy && (!r_out_valid || !i_out_stall);
    assign pkt_done   = out_load && (r_idx == r_last_idx);
    assign o_in_stall = r_busy && !pkt_done;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
        logic [2:0] ndata;
        logic [7:0] len;
        logic [7:0] addr;
        logic [7:0] sum;
        d0        = 8'h00;
        d1        = 8'h00;
        d2        = 8'h00;
        d3        = 8'h00;
        ndata     = 3'd2;
        n_kind_ok = 1'b1;
        case (i_kind)
            swpb_pkg::KIND_MOVE: begin
                d0    = i_goal_position[7:0];
                d1    = i_goal_position[15:8];
                d2    = i_moving_speed[7:0];
                d3    = i_moving_speed[15:8];
                ndata = 3'd4;
            end
            swpb_pkg::KIND_MOVE_TO: begin
                d0 = i_goal_position[7:0];
                d1 = i_goal_position[15:8];
            end
            swpb_pkg::KIND_SPEED: begin
                d0 = i_moving_speed[7:0];
                d1 = i_moving_speed[15:8];
            end
            swpb_pkg::KIND_CW_LIMIT, swpb_pkg::KIND_CCW_LIMIT,
            swpb_pkg::KIND_TORQUE_LIMIT, swpb_pkg::KIND_MAX_TORQUE: begin
                d0 = i_setting_value[7:0];
                d1 = i_setting_value[15:8];
            end
            swpb_pkg::KIND_LED, swpb_pkg::KIND_BAUD: begin
                d0    = i_setting_value[7:0];
                ndata = 3'd1;
            end
            default: begin
                n_kind_ok = 1'b0;
            end
        endcase
        len  = {5'd0, ndata} + 8'd3;
        addr = swpb_pkg::kind_addr(i_kind);
        sum  = i_servo_id + len + swpb_pkg::OPCODE_WRITE + addr + d0 + d1 + d2 + d3;

        n_pkt[0]  = swpb_pkg::SYNC_BYTE;
        n_pkt[1]  = swpb_pkg::SYNC_BYTE;
        n_pkt[2]  = i_servo_id;
        n_pkt[3]  = len;
        n_pkt[4]  = swpb_pkg::OPCODE_WRITE;
        n_pkt[5]  = addr;
        n_pkt[6]  = d0;
        n_pkt[7]  = d1;
        n_pkt[8]  = d2;
        n_pkt[9]  = d3;
        n_pkt[10] = 8'h00;
        n_last_idx = 4'd6 + {1'b0, ndata};
        n_pkt[n_last_idx] = ~sum;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pkt      <= n_pkt;
            r_last_idx <= n_last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (in_acc) begin
            r_busy <= n_kind_ok;
            r_idx  <= '0;
        end else if (out_load) begin
            if (pkt_done) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_pkt[r_idx];
            r_out_last <= (r_idx == r_last_idx);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_packet_byte = r_out_byte;
    assign o_last_byte   = r_out_last;

endmodule

// File: rtl/core/swpb_checker.sv
`timescale 1ns / 1ps
`include "servo_write_packet_builder_core_assert.svh"

module swpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [3:0]  i_kind,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_packet_byte,
    input logic        o_last_byte
);

    logic       out_held;
    logic       bad_kind_acc;
    logic [8:0] out_word;

    assign out_held     = o_out_valid && i_out_stall;
    assign bad_kind_acc = i_in_valid && !o_in_stall && (i_kind > swpb_pkg::KIND_BAUD);
    assign out_word     = {o_packet_byte, o_last_byte};

    `SWPB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))
    `SWPB_ASSERT_NOW(a_mid_pkt_stall, i_clk, i_rst_n, out_held && !o_last_byte, o_in_stall)
    `SWPB_ASSERT_NEXT(a_pending_moves, i_clk, i_rst_n, o_in_stall && !i_out_stall, o_out_valid)
    `SWPB_ASSERT_NEXT(a_bad_kind_no_stall, i_clk, i_rst_n, bad_kind_acc, !o_in_stall)

endmodule

bind servo_write_packet_builder_core swpb_checker u_swpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_kind        (i_kind),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_packet_byte (o_packet_byte),
    .o_last_byte   (o_last_byte)
);

// File: tb/sv/servo_write_packet_checker.sv
`timescale 1ns / 1ps

module servo_write_packet_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [3:0]  kind,
    input  logic [7:0]  servo_id,
    input  logic [15:0] goal_position,
    input  logic [15:0] moving_speed,
    input  logic [15:0] setting_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    output int          fail_count,
    output int          pending,
    output int          bytes_checked
);

    localparam swpb_pkg::t_byte ADDR_GOAL_POSITION = 8'h1E;
    localparam swpb_pkg::t_byte ADDR_MOVING_SPEED  = 8'h20;
    localparam swpb_pkg::t_byte ADDR_CW_LIMIT      = 8'h06;
    localparam swpb_pkg::t_byte ADDR_CCW_LIMIT     = 8'h08;
    localparam swpb_pkg::t_byte ADDR_TORQUE_LIMIT  = 8'h22;
    localparam swpb_pkg::t_byte ADDR_MAX_TORQUE    = 8'h0E;
    localparam swpb_pkg::t_byte ADDR_LED           = 8'h19;
    localparam swpb_pkg::t_byte ADDR_BAUD          = 8'h04;
    localparam int              LEN_OVERHEAD       = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_wire_byte;

    t_wire_byte packet_bytes_q[$];

    assign pending = packet_bytes_q.size();

    function automatic void build_write_packet(input logic [3:0] k,
                                               input swpb_pkg::t_byte id,
                                               input logic [15:0] pos,
                                               input logic [15:0] spd,
                                               input logic [15:0] val);
        swpb_pkg::t_byte pkt [swpb_pkg::PKT_MAX_BYTES];
        swpb_pkg::t_byte addr;
        swpb_pkg::t_byte sum;
        int              n_data;
        int              n;
        t_wire_byte      ent;
        n_data = 2;
        case (k)
            swpb_pkg::KIND_MOVE: begin
                addr = ADDR_GOAL_POSITION;
                pkt[6] = pos[7:0];
                pkt[7] = pos[15:8];
                pkt[8] = spd[7:0];
                pkt[9] = spd[15:8];
                n_data = 4;
            end
            swpb_pkg::KIND_MOVE_TO: begin
                addr = ADDR_GOAL_POSITION;
                pkt[6] = pos[7:0];
                pkt[7] = pos[15:8];
            end
            swpb_pkg::KIND_SPEED: begin
                addr = ADDR_MOVING_SPEED;
                pkt[6] = spd[7:0];
                pkt[7] = spd[15:8];
            end
            swpb_pkg::KIND_CW_LIMIT, swpb_pkg::KIND_CCW_LIMIT,
            swpb_pkg::KIND_TORQUE_LIMIT, swpb_pkg::KIND_MAX_TORQUE: begin
                case (k)
                    swpb_pkg::KIND_CW_LIMIT:     addr = ADDR_CW_LIMIT;
                    swpb_pkg::KIND_CCW_LIMIT:    addr = ADDR_CCW_LIMIT;
                    swpb_pkg::KIND_TORQUE_LIMIT: addr = ADDR_TORQUE_LIMIT;
                    default:                     addr = ADDR_MAX_TORQUE;
                endcase
                pkt[6] = val[7:0];
                pkt[7] = val[15:8];
            end
            swpb_pkg::KIND_LED, swpb_pkg::KIND_BAUD: begin
                addr = (k == swpb_pkg::KIND_LED) ? ADDR_LED : ADDR_BAUD;
                pkt[6] = val[7:0];
                n_data = 1;
            end
            default: return;
        endcase
        pkt[0] = swpb_pkg::SYNC_BYTE;
        pkt[1] = swpb_pkg::SYNC_BYTE;
        pkt[2] = id;
        pkt[3] = swpb_pkg::t_byte'(n_data + LEN_OVERHEAD);
        pkt[4] = swpb_pkg::OPCODE_WRITE;
        pkt[5] = addr;
        n = 6 + n_data;
        sum = 8'h00;
        for (int i = 2; i < n; i++)
            sum = sum + pkt[i];
        pkt[n] = ~sum;
        n++;
        for (int i = 0; i < n; i++) begin
            ent.data = pkt[i];
            ent.last = (i == n - 1);
            packet_bytes_q.push_back(ent);
        end
    endfunction

    initial begin
        fail_count    = 0;
        bytes_checked = 0;
    end

    always @(posedge clk) begin
        t_wire_byte want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                bytes_checked++;
                if (packet_bytes_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected packet byte %02h last %0b",
                                 $time, packet_byte, last_byte);
                    fail_count++;
                end else begin
                    want = packet_bytes_q.pop_front();
                    if (packet_byte !== want.data || last_byte !== want.last) begin
                        if (fail_count < 10)
                            $display({"%0t: packet byte mismatch: expected %02h last %0b,",
                                      " got %02h last %0b"},
                                     $time, want.data, want.last, packet_byte, last_byte);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                build_write_packet(kind, servo_id, goal_position, moving_speed,
                                   setting_value);
        end
    end

endmodule

// File: tb/sv/tb_servo_write_packet_builder_core.sv
`timescale 1ns / 1ps

module tb_servo_write_packet_builder_core;

    localparam int TOTAL_COMMANDS = 130;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [3:0]  i_kind          = '0;
    logic [7:0]  i_servo_id      = '0;
    logic [15:0] i_goal_position = '0;
    logic [15:0] i_moving_speed  = '0;
    logic [15:0] i_setting_value = '0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_packet_byte;
    logic        o_last_byte;

    int fail_count;
    int pending;
    int bytes_checked;
    int commands_sent  = 0;
    int undefined_sent = 0;
    int stall_mode     = 0;
    int stall_cycle    = 0;

    always #6 i_clk = ~i_clk;

    servo_write_packet_builder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_servo_id      (i_servo_id),
        .i_goal_position (i_goal_position),
        .i_moving_speed  (i_moving_speed),
        .i_setting_value (i_setting_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_packet_byte   (o_packet_byte),
        .o_last_byte     (o_last_byte)
    );

    servo_write_packet_checker u_checker (
        .clk           (i_clk),
        .rst_n         (i_rst_n),
        .in_valid      (i_in_valid),
        .in_stall      (o_in_stall),
        .kind          (i_kind),
        .servo_id      (i_servo_id),
        .goal_position (i_goal_position),
        .moving_speed  (i_moving_speed),
        .setting_value (i_setting_value),
        .out_valid     (o_out_valid),
        .out_stall     (i_out_stall),
        .packet_byte   (o_packet_byte),
        .last_byte     (o_last_byte),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 7) == 0);
                2: i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= (stall_cycle % 5 < 2);
            endcase
        end
    end

    task automatic send_command(input logic [3:0] k, input logic [7:0] id,
                                input logic [15:0] pos, input logic [15:0] spd,
                                input logic [15:0] val);
        i_in_valid      <= 1'b1;
        i_kind          <= k;
        i_servo_id      <= id;
        i_goal_position <= pos;
        i_moving_speed  <= spd;
        i_setting_value <= val;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        commands_sent++;
        if (k > swpb_pkg::KIND_BAUD)
            undefined_sent++;
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          defined_sent;
        int          burst_left;
        int          wait_cycles;
        bit          no_gaps;
        logic [3:0]  k;

        defined_sent = 0;
        burst_left   = 0;
        no_gaps      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(swpb_pkg::KIND_MOVE,         8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_command(swpb_pkg::KIND_MOVE,         8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(swpb_pkg::KIND_MOVE_TO,      8'h01, 16'h1234, 16'hFFFF, 16'hFFFF);
        send_command(swpb_pkg::KIND_SPEED,        8'hFE, 16'h5555, 16'hFFFF, 16'hAAAA);
        send_command(swpb_pkg::KIND_CW_LIMIT,     8'h7F, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_command(swpb_pkg::KIND_CCW_LIMIT,    8'h80, 16'h0000, 16'h0000, 16'hFFFF);
        hold_off(3);
        send_command(swpb_pkg::KIND_TORQUE_LIMIT, 8'h10, 16'hA5A5, 16'h5A5A, 16'h03FF);
        send_command(swpb_pkg::KIND_MAX_TORQUE,   8'hFF, 16'h0000, 16'h0000, 16'h8000);
        send_command(swpb_pkg::KIND_LED,          8'h22, 16'hFFFF, 16'hFFFF, 16'hFF01);
        send_command(swpb_pkg::KIND_LED,          8'h00, 16'h0000, 16'h0000, 16'h00DF);
        send_command(swpb_pkg::KIND_BAUD,         8'hFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_command(swpb_pkg::KIND_BAUD,         8'h01, 16'hFFFF, 16'hFFFF, 16'h0001);
        send_command(4'd9,                        8'h55, 16'h1111, 16'h2222, 16'h3333);
        send_command(swpb_pkg::KIND_MOVE_TO,      8'hFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_command(4'd15,                       8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        hold_off(1);
        send_command(4'd12,                       8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_command(swpb_pkg::KIND_SPEED,        8'h00, 16'h0000, 16'h0000, 16'h0000);

        while (commands_sent < TOTAL_COMMANDS) begin
            if ($urandom_range(0, 9) == 0)
                k = 4'($urandom_range(9, 15));
            else
                k = 4'($urandom_range(0, 8));
            send_command(k, 8'($urandom), pick_word(), pick_word(), pick_word());
            if (k <= swpb_pkg::KIND_BAUD)
                defined_sent++;
            if (defined_sent % 40 == 0)
                no_gaps = ~no_gaps;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 7);
                if (!no_gaps)
                    hold_off($urandom_range(0, 12));
            end
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (24) @(posedge i_clk);

        $display("Sent %0d commands (%0d of undefined kind) in bursts under output stalls.",
                 commands_sent, undefined_sent);
        $display("Checked %0d packet bytes across all nine write kinds.", bytes_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d packet bytes never arrived", fail_count, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timed out with %0d packet bytes outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
